FILE: design/rwu_pkg.sv
// Package for the Reno window update block: sequencer states, shared unit
// operation codes, configuration register indexes, reset values and the
// configuration bundle type. No dependencies.
package rwu_pkg;

	localparam int SegWidth     = 16;
	localparam int CwndWidth    = 16;
	localparam int CountWidth   = 18;
	localparam int CreditWidth  = 32;
	localparam int AluWidth     = 33;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SEGMENT_SIZE      = 3'd0;
	localparam logic [2:0] REG_WINDOW_CLAMP      = 3'd1;
	localparam logic [2:0] REG_LIMITED_SS_MAX    = 3'd2;
	localparam logic [2:0] REG_BYTE_COUNT_MODE   = 3'd3;
	localparam logic [2:0] REG_OFFLOAD_DIVISOR   = 3'd4;
	localparam logic [2:0] REG_OFFLOAD_MAX_BYTES = 3'd5;
	localparam logic [2:0] REG_BURST_ALLOWANCE   = 3'd6;
	localparam logic [2:0] REG_INITIAL_WINDOW    = 3'd7;

	// Byte counting modes; the fourth code behaves like the doubling mode.
	localparam logic [1:0] BC_OFF = 2'd0;

	localparam logic [15:0] RST_SEGMENT_SIZE      = 16'd1460;
	localparam logic [15:0] RST_WINDOW_CLAMP      = 16'd65535;
	localparam logic [15:0] RST_LIMITED_SS_MAX    = 16'd0;
	localparam logic [1:0]  RST_BYTE_COUNT_MODE   = 2'd0;
	localparam logic [7:0]  RST_OFFLOAD_DIVISOR   = 8'd3;
	localparam logic [15:0] RST_OFFLOAD_MAX_BYTES = 16'd0;
	localparam logic [7:0]  RST_BURST_ALLOWANCE   = 8'd3;
	localparam logic [15:0] RST_INITIAL_WINDOW    = 16'd10;

	localparam logic [14:0] MIN_THRESHOLD = 15'd2;
	localparam logic [1:0]  LAST_PASS     = 2'd2;

	typedef struct packed {
		logic [15:0] segment_size;
		logic [15:0] window_clamp;
		logic [15:0] limited_ss_max;
		logic [1:0]  byte_count_mode;
		logic [7:0]  offload_divisor;
		logic [15:0] offload_max_bytes;
		logic [7:0]  burst_allowance;
	} rwu_cfg_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} rwu_alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CREDIT,
		ST_LEFT,
		ST_OFF_DIV,
		ST_OFF_SEG,
		ST_OFF_CMP,
		ST_BURST,
		ST_SELECT,
		ST_SS_ADD,
		ST_SS_LOOP,
		ST_CA_MUL,
		ST_CA_SUB,
		ST_CA_CNT,
		ST_FINISH
	} rwu_state_t;

endpackage

FILE: design/tcp_reno_window_update.sv
// Top level of the Reno congestion window update block with byte counting.
// Depends on rwu_pkg, rwu_cfg (register file) and rwu_alu (shared unit).
//
// Channel  Direction  Handshake              Contents
// in       to block   in_valid / in_ready    acked_bytes, packets_in_flight, ss_threshold
// out      from block out_valid / out_ready  cwnd_now, window_limited, suggested_threshold
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request is stepped from acceptance to its result being loaded by the sequencer,
// which drives one shared add, subtract and multiply unit through the credit update, the
// window test, the offload test where enabled, the burst test, the mode select, the growth
// step and the slow start carry of up to three passes; some tests skip what follows them.
// A new request is taken only back in idle. Reset clears the window to the initial window,
// the counter and the credit. A waiting result only stalls the final step.
module tcp_reno_window_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] acked_bytes,
	input  logic [15:0] packets_in_flight,
	input  logic [15:0] ss_threshold,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cwnd_now,
	output logic        window_limited,
	output logic [14:0] suggested_threshold,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = rwu_pkg::AluWidth;

	rwu_pkg::rwu_cfg_t    cfg;
	rwu_pkg::rwu_state_t  state_q, state_d;
	rwu_pkg::rwu_alu_op_t alu_op;
	logic [AW-1:0]        alu_a, alu_b;
	logic [AW:0]          alu_y;

	// Per-connection state.
	logic [15:0] cwnd_q;
	logic [17:0] gcnt_q;
	logic [31:0] credit_q;

	// Captured request and working registers.
	logic [23:0] acked_q;
	logic [15:0] inflight_q;
	logic [15:0] ssth_q;
	logic [15:0] left_q;
	logic [31:0] acc_q;
	logic        off_lt_q;
	logic        limited_q;
	logic [1:0]  pass_q;

	// Output register.
	logic        out_valid_q;
	logic [15:0] cwnd_now_q;
	logic        limited_out_q;
	logic [14:0] thresh_q;

	// Decision terms used by the sequencer and the datapath.
	logic        borrow;
	logic        left_zero;
	logic        off_hit;
	logic        burst_hit;
	logic        ss_blocked;
	logic        ss_double;
	logic [15:0] ss_base;
	logic [16:0] ss_cnt;
	logic        can_grow;
	logic [15:0] cwnd_inc;
	logic        out_free;
	logic [14:0] half;

	rwu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rwu_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign cfg_ready = 1'b1;

	assign borrow    = alu_y[AW];
	assign left_zero = (alu_y[15:0] == 16'd0);
	assign off_hit   = off_lt_q && (acc_q < {16'd0, cfg.offload_max_bytes});
	assign burst_hit = (left_q <= {8'd0, cfg.burst_allowance});
	assign can_grow  = (cwnd_q < cfg.window_clamp);
	assign cwnd_inc  = cwnd_q + 16'd1;
	assign out_free  = !out_valid_q || out_ready;

	// Slow start: with byte counting on, a credit short of one segment stops
	// all growth. Limited slow start caps the step at half its threshold.
	assign ss_blocked = (cfg.byte_count_mode != rwu_pkg::BC_OFF)
		&& (credit_q < {16'd0, cfg.segment_size});
	assign ss_base = ((cfg.limited_ss_max != 16'd0) && (cwnd_q > cfg.limited_ss_max))
		? {1'b0, cfg.limited_ss_max[15:1]} : cwnd_q;
	assign ss_double = cfg.byte_count_mode[1]
		&& ({1'b0, credit_q} >= {16'd0, cfg.segment_size, 1'b0});
	assign ss_cnt = ss_double ? {ss_base, 1'b0} : {1'b0, ss_base};

	assign half = (cwnd_q[15:2] == 14'd0) ? rwu_pkg::MIN_THRESHOLD : cwnd_q[15:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		alu_op   = rwu_pkg::ALU_ADD;
		alu_a    = '0;
		alu_b    = '0;
		case (state_q)
			rwu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = rwu_pkg::ST_CREDIT;
				end
			end
			rwu_pkg::ST_CREDIT: begin
				alu_op  = rwu_pkg::ALU_ADD;
				alu_a   = {1'b0, credit_q};
				alu_b   = {9'd0, acked_q};
				state_d = rwu_pkg::ST_LEFT;
			end
			rwu_pkg::ST_LEFT: begin
				// A borrow or a zero difference means in flight reaches cwnd.
				alu_op = rwu_pkg::ALU_SUB;
				alu_a  = {17'd0, cwnd_q};
				alu_b  = {17'd0, inflight_q};
				if (borrow || left_zero) begin
					state_d = rwu_pkg::ST_SELECT;
				end else if (cfg.offload_max_bytes != 16'd0) begin
					state_d = rwu_pkg::ST_OFF_DIV;
				end else begin
					state_d = rwu_pkg::ST_BURST;
				end
			end
			rwu_pkg::ST_OFF_DIV: begin
				alu_op  = rwu_pkg::ALU_MUL;
				alu_a   = {17'd0, left_q};
				alu_b   = {25'd0, cfg.offload_divisor};
				state_d = rwu_pkg::ST_OFF_SEG;
			end
			rwu_pkg::ST_OFF_SEG: begin
				alu_op  = rwu_pkg::ALU_MUL;
				alu_a   = {17'd0, left_q};
				alu_b   = {17'd0, cfg.segment_size};
				state_d = rwu_pkg::ST_OFF_CMP;
			end
			rwu_pkg::ST_OFF_CMP: begin
				state_d = off_hit ? rwu_pkg::ST_SELECT : rwu_pkg::ST_BURST;
			end
			rwu_pkg::ST_BURST: begin
				state_d = burst_hit ? rwu_pkg::ST_SELECT : rwu_pkg::ST_FINISH;
			end
			rwu_pkg::ST_SELECT: begin
				if (cwnd_q <= ssth_q) begin
					state_d = rwu_pkg::ST_SS_ADD;
				end else if (cfg.byte_count_mode != rwu_pkg::BC_OFF) begin
					state_d = rwu_pkg::ST_CA_MUL;
				end else begin
					state_d = rwu_pkg::ST_CA_CNT;
				end
			end
			rwu_pkg::ST_SS_ADD: begin
				alu_op  = rwu_pkg::ALU_ADD;
				alu_a   = {15'd0, gcnt_q};
				alu_b   = {16'd0, ss_cnt};
				state_d = ss_blocked ? rwu_pkg::ST_FINISH : rwu_pkg::ST_SS_LOOP;
			end
			rwu_pkg::ST_SS_LOOP: begin
				// Each pass that finds a window's worth on the counter takes it off
				// and grows the window by one up to the clamp, at most three passes.
				alu_op = rwu_pkg::ALU_SUB;
				alu_a  = {15'd0, gcnt_q};
				alu_b  = {17'd0, cwnd_q};
				if (borrow || (pass_q == rwu_pkg::LAST_PASS)) begin
					state_d = rwu_pkg::ST_FINISH;
				end
			end
			rwu_pkg::ST_CA_MUL: begin
				alu_op  = rwu_pkg::ALU_MUL;
				alu_a   = {17'd0, cwnd_q};
				alu_b   = {17'd0, cfg.segment_size};
				state_d = rwu_pkg::ST_CA_SUB;
			end
			rwu_pkg::ST_CA_SUB: begin
				alu_op  = rwu_pkg::ALU_SUB;
				alu_a   = {1'b0, credit_q};
				alu_b   = {1'b0, acc_q};
				state_d = rwu_pkg::ST_FINISH;
			end
			rwu_pkg::ST_CA_CNT: begin
				alu_op  = rwu_pkg::ALU_SUB;
				alu_a   = {15'd0, gcnt_q};
				alu_b   = {17'd0, cwnd_q};
				state_d = rwu_pkg::ST_FINISH;
			end
			rwu_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = rwu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rwu_pkg::ST_IDLE;
			end
		endcase
	end

	// Connection state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cwnd_q   <= rwu_pkg::RST_INITIAL_WINDOW;
			gcnt_q   <= '0;
			credit_q <= '0;
		end else begin
			case (state_q)
				rwu_pkg::ST_CREDIT: begin
					// The credit saturates rather than wrapping.
					credit_q <= alu_y[32] ? '1 : alu_y[31:0];
				end
				rwu_pkg::ST_SS_ADD: begin
					if (!ss_blocked) begin
						credit_q <= '0;
						gcnt_q   <= alu_y[17:0];
					end
				end
				rwu_pkg::ST_SS_LOOP: begin
					if (!borrow) begin
						gcnt_q <= alu_y[17:0];
						if (can_grow) begin
							cwnd_q <= cwnd_inc;
						end
					end
				end
				rwu_pkg::ST_CA_SUB: begin
					if (!borrow) begin
						credit_q <= alu_y[31:0];
						if (can_grow) begin
							cwnd_q <= cwnd_inc;
						end
					end
				end
				rwu_pkg::ST_CA_CNT: begin
					if (!borrow) begin
						gcnt_q <= '0;
						if (can_grow) begin
							cwnd_q <= cwnd_inc;
						end
					end else begin
						gcnt_q <= gcnt_q + 18'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limited_q <= 1'b0;
			pass_q    <= '0;
		end else begin
			case (state_q)
				rwu_pkg::ST_IDLE: begin
					limited_q <= 1'b0;
					pass_q    <= '0;
				end
				rwu_pkg::ST_SELECT: begin
					limited_q <= 1'b1;
				end
				rwu_pkg::ST_SS_LOOP: begin
					pass_q <= pass_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rwu_pkg::ST_IDLE: begin
				if (in_valid) begin
					acked_q    <= acked_bytes;
					inflight_q <= packets_in_flight;
					ssth_q     <= ss_threshold;
				end
			end
			rwu_pkg::ST_LEFT: begin
				left_q <= alu_y[15:0];
			end
			rwu_pkg::ST_OFF_DIV: begin
				acc_q <= alu_y[31:0];
			end
			rwu_pkg::ST_OFF_SEG: begin
				off_lt_q <= (acc_q < {16'd0, cwnd_q});
				acc_q    <= alu_y[31:0];
			end
			rwu_pkg::ST_CA_MUL: begin
				acc_q <= alu_y[31:0];
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == rwu_pkg::ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == rwu_pkg::ST_FINISH) && out_free) begin
			cwnd_now_q    <= cwnd_q;
			limited_out_q <= limited_q;
			thresh_q      <= half;
		end
	end

	assign out_valid           = out_valid_q;
	assign cwnd_now            = cwnd_now_q;
	assign window_limited      = limited_out_q;
	assign suggested_threshold = thresh_q;

endmodule

FILE: design/rwu_cfg.sv
// Configuration register file of the Reno window update block.
// Depends on rwu_pkg for register indexes, reset values and the bundle type.
module rwu_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output rwu_pkg::rwu_cfg_t cfg
);

	rwu_pkg::rwu_cfg_t cfg_q;

	// The initial window index has no register here, so a write to it is
	// ignored; the window takes the fixed reset value from the package.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segment_size      <= rwu_pkg::RST_SEGMENT_SIZE;
			cfg_q.window_clamp      <= rwu_pkg::RST_WINDOW_CLAMP;
			cfg_q.limited_ss_max    <= rwu_pkg::RST_LIMITED_SS_MAX;
			cfg_q.byte_count_mode   <= rwu_pkg::RST_BYTE_COUNT_MODE;
			cfg_q.offload_divisor   <= rwu_pkg::RST_OFFLOAD_DIVISOR;
			cfg_q.offload_max_bytes <= rwu_pkg::RST_OFFLOAD_MAX_BYTES;
			cfg_q.burst_allowance   <= rwu_pkg::RST_BURST_ALLOWANCE;
		end else if (wr_en) begin
			case (wr_index)
				rwu_pkg::REG_SEGMENT_SIZE:      cfg_q.segment_size      <= wr_data;
				rwu_pkg::REG_WINDOW_CLAMP:      cfg_q.window_clamp      <= wr_data;
				rwu_pkg::REG_LIMITED_SS_MAX:    cfg_q.limited_ss_max    <= wr_data;
				rwu_pkg::REG_BYTE_COUNT_MODE:   cfg_q.byte_count_mode   <= wr_data[1:0];
				rwu_pkg::REG_OFFLOAD_DIVISOR:   cfg_q.offload_divisor   <= wr_data[7:0];
				rwu_pkg::REG_OFFLOAD_MAX_BYTES: cfg_q.offload_max_bytes <= wr_data;
				rwu_pkg::REG_BURST_ALLOWANCE:   cfg_q.burst_allowance   <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/rwu_alu.sv
// Shared arithmetic unit of the Reno window update block: add, subtract with
// borrow out, and a 16 by 16 multiply. Depends on rwu_pkg for the op codes.
module rwu_alu (
	input  rwu_pkg::rwu_alu_op_t          op,
	input  logic [rwu_pkg::AluWidth-1:0]  a,
	input  logic [rwu_pkg::AluWidth-1:0]  b,
	output logic [rwu_pkg::AluWidth:0]    y
);

	logic [31:0] prod;

	assign prod = a[15:0] * b[15:0];

	always_comb begin
		case (op)
			rwu_pkg::ALU_ADD: y = {1'b0, a} + {1'b0, b};
			rwu_pkg::ALU_SUB: y = {1'b0, a} - {1'b0, b};
			rwu_pkg::ALU_MUL: y = {2'b00, prod};
			default:          y = '0;
		endcase
	end

endmodule
